FILE: rtl/psfp_pkg.sv
// Shared types and constants for the particle sensor frame parser.
// No dependencies; used by psfp_core and particle_sensor_frame_parser.
package psfp_pkg;

	localparam int unsigned FRAME_BYTES_DEF = 32;
	localparam int unsigned IDX_W = 6;

	localparam logic [7:0] START_BYTE  = 8'h42;
	localparam logic [7:0] SECOND_BYTE = 8'h4D;
	localparam logic [IDX_W-1:0] PM_HIGH_POS = IDX_W'(12);
	localparam logic [IDX_W-1:0] PM_LOW_POS  = IDX_W'(13);

	typedef enum logic [1:0] {
		ST_VALID    = 2'd0,
		ST_BAD_HDR  = 2'd1,
		ST_BAD_SUM  = 2'd2
	} psfp_status_t;

	typedef struct packed {
		logic         valid;
		logic [15:0]  value;
		psfp_status_t status;
	} psfp_result_t;

endpackage

FILE: rtl/psfp_core.sv
// Frame tracking state and result logic for the particle sensor frame parser.
// Depends on psfp_pkg.
module psfp_core #(
	parameter int unsigned FRAME_BYTES = psfp_pkg::FRAME_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           data,
	output psfp_pkg::psfp_result_t res
);
	import psfp_pkg::*;

	localparam logic [IDX_W-1:0] CHECK_HIGH_POS = IDX_W'(FRAME_BYTES - 2);
	localparam logic [IDX_W-1:0] LAST_POS       = IDX_W'(FRAME_BYTES - 1);

	logic             in_frame_q;
	logic [IDX_W-1:0] idx_q;
	logic [15:0]      sum_q;
	logic             header_good_q;
	logic [15:0]      pm_q;
	logic [7:0]       chk_hi_q;

	logic [15:0] stored;
	logic        last;

	assign last   = in_frame_q && (idx_q >= LAST_POS);
	assign stored = {chk_hi_q, data};

	always_comb begin
		res.valid  = step && last;
		res.value  = 16'd0;
		res.status = ST_VALID;
		if (!header_good_q) begin
			res.status = ST_BAD_HDR;
		end else if (stored != sum_q) begin
			res.status = ST_BAD_SUM;
		end else begin
			res.value = pm_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q    <= 1'b0;
			idx_q         <= '0;
			sum_q         <= '0;
			header_good_q <= 1'b0;
			pm_q          <= '0;
			chk_hi_q      <= '0;
		end else if (step) begin
			if (!in_frame_q) begin
				if (data == START_BYTE) begin
					in_frame_q    <= 1'b1;
					idx_q         <= IDX_W'(1);
					sum_q         <= {8'd0, data};
					header_good_q <= 1'b0;
					pm_q          <= '0;
					chk_hi_q      <= '0;
				end
			end else begin
				if (idx_q == IDX_W'(1))
					header_good_q <= (data == SECOND_BYTE);
				if (idx_q < CHECK_HIGH_POS)
					sum_q <= sum_q + {8'd0, data};
				if (idx_q == PM_HIGH_POS)
					pm_q[15:8] <= data;
				if (idx_q == PM_LOW_POS)
					pm_q[7:0] <= data;
				if (idx_q == CHECK_HIGH_POS)
					chk_hi_q <= data;
				if (last) begin
					in_frame_q <= 1'b0;
					idx_q      <= '0;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
		end
	end

endmodule

FILE: rtl/particle_sensor_frame_parser.sv
// Particle sensor frame parser: an accepted byte passes the input register, then the result register, to its result.
// Throughput one byte per cycle; the input register and the result register
// decouple the two channels, so a waiting result does not stall byte intake
// until both stages are full.
// arst_n clears the frame state and both valid flags; the parser then waits for 0x42.
// Depends on psfp_pkg and psfp_core.
module particle_sensor_frame_parser #(
	parameter int unsigned FRAME_BYTES = psfp_pkg::FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] pm25_value,
	output logic [1:0]  frame_status
);
	import psfp_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         adv_s1;
	logic         step;
	psfp_result_t res;
	logic         out_valid_q;
	logic [15:0]  value_q;
	psfp_status_t status_q;

	assign adv_s1   = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv_s1;
	assign step     = valid_s1 && adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			byte_s1 <= rx_byte;
	end

	psfp_core #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.data  (byte_s1),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			value_q  <= res.value;
			status_q <= res.status;
		end
	end

	assign out_valid    = out_valid_q;
	assign pm25_value   = value_q;
	assign frame_status = status_q;

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_status == ST_VALID || frame_status == ST_BAD_HDR ||
			frame_status == ST_BAD_SUM))
		else $error("frame status out of range");

	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_status != ST_VALID |-> pm25_value == 16'd0)
		else $error("nonzero value on bad frame");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled with empty stage");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1))
		else $error("result without a request in stage 1");

endmodule
